@@ hw/rtl/separable_conv2d_border_replicate_defines.svh @@
// assertion macros for the separable convolution block
`ifndef SEPARABLE_CONV2D_BORDER_REPLICATE_DEFINES_SVH
`define SEPARABLE_CONV2D_BORDER_REPLICATE_DEFINES_SVH

// same-cycle implication, checked on clk outside reset
`define SC2D_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk outside reset
`define SC2D_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/sc2d_pkg.sv @@
// shared types, register codes and coefficient table of the separable convolution
`default_nettype none
package sc2d_pkg;

  localparam int COEF_W = 10;
  typedef logic [COEF_W-1:0] coef_t;

  localparam coef_t COEF_TABLE [11] = '{
    10'd36, 10'd111, 10'd266, 10'd498, 10'd724, 10'd821,
    10'd724, 10'd498, 10'd266, 10'd111, 10'd36
  };

  // register select on paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // tap i of a filter with the given half width, centred on entry five
  function automatic coef_t tap_coef(input int half, input int i);
    int idx;
    idx = i - half + 5;
    if (idx < 0 || idx > 10) begin
      return '0;
    end
    return COEF_TABLE[idx];
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/separable_conv2d_border_replicate.sv @@
// top level: separable 2-d convolution with line store and border replication
// an accepted pixel runs its TAPS horizontal taps on one shared multiplier
// a pixel that completes a centre with enough rows then sums its vertical taps from the line store
// and emits its results one per cycle unless out_stall holds them, up to (TAPS/2+1)^2,
// the last marked by out_run_last; in_stall refuses a new pixel until the block is idle again
// reset: synchronous active low clears counters and control; data and line store are not cleared
`default_nettype none
`include "separable_conv2d_border_replicate_defines.svh"
module separable_conv2d_border_replicate #(
  parameter int TAPS       = 11,
  parameter int MAX_COLS   = 2048,
  parameter int MAX_ROWS   = 2048,
  parameter int PIXEL_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // pixel input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_pixel_in,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [10:0]      out_row,
  output logic [10:0]      out_col,
  output logic [15:0]      out_value,
  output logic             out_run_last,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import sc2d_pkg::*;

  localparam int HALF     = TAPS / 2;
  localparam int TAIL     = TAPS - 1 - HALF;
  localparam int LINES    = TAPS - 1;
  localparam int MAX_RES  = (HALF + 1) * (HALF + 1);
  localparam int CW       = $clog2(MAX_COLS + 1);
  localparam int RW       = $clog2(MAX_ROWS + 1);
  localparam int COL_BITS = $clog2(MAX_COLS);
  localparam int LB       = $clog2(LINES);
  localparam int AW       = LB + COL_BITS;
  localparam int DEPTH    = LINES << COL_BITS;
  localparam int HI_W     = $clog2(TAPS);
  localparam int VI_W     = $clog2(LINES + 1);
  localparam int N_W      = $clog2(MAX_RES);
  localparam int PROD_W   = PIXEL_BITS + COEF_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HSUM = 3'd1;
  localparam logic [2:0] S_VSUM = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;

  // ---------------- configuration registers ----------------
  logic [11:0] frame_width_r, frame_height_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 12'd1920;
      frame_height_r <= 12'd1080;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_WIDTH:  frame_width_r  <= pwdata[11:0];
        REG_HEIGHT: frame_height_r <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WIDTH:  prdata = {20'd0, frame_width_r};
      REG_HEIGHT: prdata = {20'd0, frame_height_r};
      default:    prdata = '0;
    endcase
  end

  // clamp dimensions: above the maximum takes the maximum, zero takes one
  logic [CW-1:0] w_eff;
  logic [RW-1:0] h_eff;

  always_comb begin
    if (frame_width_r == 12'd0) begin
      w_eff = CW'(1);
    end else if ({1'b0, frame_width_r} > 13'(MAX_COLS)) begin
      w_eff = CW'(MAX_COLS);
    end else begin
      w_eff = CW'(frame_width_r);
    end
    if (frame_height_r == 12'd0) begin
      h_eff = RW'(1);
    end else if ({1'b0, frame_height_r} > 13'(MAX_ROWS)) begin
      h_eff = RW'(MAX_ROWS);
    end else begin
      h_eff = RW'(frame_height_r);
    end
  end

  // ---------------- control state ----------------
  logic [2:0]      state_r, state_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic [LB-1:0]   lp_r, lp_nxt;       // row index modulo the line count
  logic [HI_W-1:0] hi_r, hi_nxt;
  logic [VI_W-1:0] vi_r, vi_nxt;
  logic [LB-1:0]   vl_r, vl_nxt;       // line currently read
  logic [N_W-1:0]  n_r, n_nxt;
  logic            out_valid_r, out_valid_nxt;

  // per transaction data
  logic            fill_r;             // centre completes, line store is written
  logic            rok_r;              // enough rows for a vertical sum
  logic [CW-1:0]   hx_r;
  logic [RW-1:0]   ey_r, rhi_r;
  logic [CW-1:0]   ex_r, clo_r, chi_r;
  logic [PIXEL_BITS-1:0] acc_h_r, acc_v_r;
  logic [PIXEL_BITS-1:0] win_r [TAPS];

  // output register
  logic [10:0] out_row_r, out_col_r;
  logic [15:0] out_value_r;
  logic        out_last_r;

  // line store
  logic [PIXEL_BITS-1:0] mem [DEPTH];
  logic [PIXEL_BITS-1:0] rd_q;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic                  mem_we;
  logic [PIXEL_BITS-1:0] wr_data;

  logic in_acc;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // position of the accepted pixel
  logic          col_wrap;
  logic [RW-1:0] r_cur, r_inc;
  logic [CW-1:0] c_cur;
  logic [LB-1:0] lp_cur, lp_inc;
  logic [CW-1:0] hx_cur;
  logic [RW-1:0] y_cur;

  always_comb begin
    col_wrap = (col_r >= w_eff);
    r_inc    = col_wrap ? RW'(row_r + RW'(1)) : row_r;
    if (col_wrap) begin
      lp_inc = (lp_r == LB'(LINES - 1)) ? '0 : LB'(lp_r + LB'(1));
    end else begin
      lp_inc = lp_r;
    end
    if (r_inc >= h_eff) begin
      r_cur  = '0;
      lp_cur = '0;
    end else begin
      r_cur  = r_inc;
      lp_cur = lp_inc;
    end
    c_cur  = col_wrap ? '0 : col_r;
    hx_cur = CW'(c_cur - CW'(TAIL));
    y_cur  = RW'(r_cur - RW'(TAIL));
  end

  // shared multiplier: horizontal taps, then hsum and stored lines
  logic [PIXEL_BITS-1:0] mul_a;
  coef_t                 mul_c;
  logic [PROD_W-1:0]     mul_full;
  logic [PIXEL_BITS-1:0] mul_p;

  always_comb begin
    case (state_r)
      S_HSUM: begin
        mul_a = win_r[hi_r];
        mul_c = tap_coef(HALF, int'(hi_r));
      end
      S_VSUM: begin
        if (vi_r == '0) begin
          mul_a = acc_h_r;
          mul_c = tap_coef(HALF, LINES);
        end else begin
          mul_a = rd_q;
          mul_c = tap_coef(HALF, int'(vi_r) - 1);
        end
      end
      default: begin
        mul_a = '0;
        mul_c = '0;
      end
    endcase
    mul_full = PROD_W'(mul_a) * PROD_W'(mul_c);
    mul_p    = mul_full[PIXEL_BITS-1:0];
  end

  logic [PIXEL_BITS-1:0] acc_h_nxt, acc_v_nxt;
  logic                  emit_go, emit_last;
  logic                  h_done;

  assign h_done    = (state_r == S_HSUM) && (hi_r == HI_W'(TAPS - 1));
  assign emit_go   = (state_r == S_EMIT) && (!out_valid_r || !out_stall);
  assign emit_last = ((ey_r == rhi_r) && (ex_r == chi_r)) || (n_r == N_W'(MAX_RES - 1));

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    lp_nxt        = lp_r;
    hi_nxt        = hi_r;
    vi_nxt        = vi_r;
    vl_nxt        = vl_r;
    n_nxt         = n_r;
    acc_h_nxt     = acc_h_r;
    acc_v_nxt     = acc_v_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    wr_data       = acc_h_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          col_nxt   = CW'(c_cur + CW'(1));
          row_nxt   = r_cur;
          lp_nxt    = lp_cur;
          hi_nxt    = '0;
          state_nxt = S_HSUM;
        end
      end
      S_HSUM: begin
        acc_h_nxt = (hi_r == '0) ? mul_p : PIXEL_BITS'(acc_h_r + mul_p);
        hi_nxt    = HI_W'(hi_r + HI_W'(1));
        if (h_done) begin
          if (!fill_r) begin
            state_nxt = S_IDLE;
          end else if (!rok_r) begin
            // rows still filling: only store the horizontal sum
            mem_we    = 1'b1;
            wr_data   = acc_h_nxt;
            state_nxt = S_IDLE;
          end else begin
            vi_nxt    = '0;
            vl_nxt    = lp_r;
            state_nxt = S_VSUM;
          end
        end
      end
      S_VSUM: begin
        acc_v_nxt = (vi_r == '0) ? mul_p : PIXEL_BITS'(acc_v_r + mul_p);
        vi_nxt    = VI_W'(vi_r + VI_W'(1));
        vl_nxt    = (vl_r == LB'(LINES - 1)) ? '0 : LB'(vl_r + LB'(1));
        if (vi_r == VI_W'(LINES)) begin
          // oldest line is read already, replace it with this row's sum
          mem_we    = 1'b1;
          n_nxt     = '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          n_nxt         = N_W'(n_r + N_W'(1));
          if (emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign rd_addr = {vl_r, hx_r[COL_BITS-1:0]};
  assign wr_addr = {lp_r, hx_r[COL_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      lp_r        <= '0;
      hi_r        <= '0;
      vi_r        <= '0;
      vl_r        <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      lp_r        <= lp_nxt;
      hi_r        <= hi_nxt;
      vi_r        <= vi_nxt;
      vl_r        <= vl_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    acc_h_r <= acc_h_nxt;
    acc_v_r <= acc_v_nxt;
    if (in_acc) begin
      for (int j = 0; j < TAPS - 1; j++) begin
        win_r[j] <= win_r[j+1];
      end
      win_r[TAPS-1] <= PIXEL_BITS'(in_pixel_in);
      fill_r <= (w_eff >= CW'(TAPS)) && (h_eff >= RW'(TAPS)) && (c_cur >= CW'(TAPS - 1));
      rok_r  <= (r_cur >= RW'(TAPS - 1));
      hx_r   <= hx_cur;
      // replicated range: the outermost centres also cover the border
      ey_r   <= (y_cur == RW'(HALF)) ? '0 : y_cur;
      rhi_r  <= (y_cur == RW'(h_eff - RW'(1 + TAIL))) ? RW'(h_eff - RW'(1)) : y_cur;
      ex_r   <= (hx_cur == CW'(HALF)) ? '0 : hx_cur;
      clo_r  <= (hx_cur == CW'(HALF)) ? '0 : hx_cur;
      chi_r  <= (hx_cur == CW'(w_eff - CW'(1 + TAIL))) ? CW'(w_eff - CW'(1)) : hx_cur;
    end else if (emit_go) begin
      if (ex_r == chi_r) begin
        ex_r <= clo_r;
        ey_r <= RW'(ey_r + RW'(1));
      end else begin
        ex_r <= CW'(ex_r + CW'(1));
      end
    end
    if (emit_go) begin
      out_row_r   <= 11'(ey_r);
      out_col_r   <= 11'(ex_r);
      out_value_r <= 16'(acc_v_r);
      out_last_r  <= emit_last;
    end
  end

  // line store, one read and one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  assign out_valid    = out_valid_r;
  assign out_row      = out_row_r;
  assign out_col      = out_col_r;
  assign out_value    = out_value_r;
  assign out_run_last = out_last_r;

  `SC2D_ASSERT_NEXT(a_accept_starts, in_acc, state_r == S_HSUM, "accepted pixel did not start")
  `SC2D_ASSERT_NOW(a_write_state, mem_we, state_r == S_HSUM || state_r == S_VSUM, "stray write")
  `SC2D_ASSERT_NOW(a_result_bound, state_r == S_EMIT, n_r < N_W'(MAX_RES), "too many results")
  `SC2D_ASSERT_NEXT(a_last_ends, emit_go && emit_last, state_r == S_IDLE, "last did not end")

endmodule
`default_nettype wire
